// ===== src/cm45_pkg.sv =====
// Package for the 4x5 color matrix block: pixel types, fixed-point widths
// and the preset coefficient table. No dependencies.
`timescale 1ns / 1ps

package cm45_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int MASTER_FRAC    = 16;
  localparam int NUM_PRESETS    = 6;
  localparam int NUM_COEF       = 20;
  localparam int NUM_CH         = 4;
  localparam int ROW_STRIDE     = 5;
  localparam int OFS_COL        = 4;

  // Coefficient magnitudes stay below 2^23 at 16 fraction bits.
  localparam int COEF_W = COEF_FRAC_BITS + 9;
  localparam int PROD_W = COEF_W + 9;
  localparam int SUM_W  = PROD_W + 3;

  localparam int SHIFT  = MASTER_FRAC - COEF_FRAC_BITS;
  localparam int HALF_M = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;

  typedef logic [7:0]               chan_t;
  typedef logic [NUM_CH-1:0][7:0]   pix_t;
  typedef logic [2:0]               preset_t;
  typedef logic [4:0]               cidx_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // Q.16 master values, row-major: R, G, B, A coefficients then offset.
  localparam int MASTER_TBL [NUM_PRESETS][NUM_COEF] = '{
    // polaroid
    '{ 94241, -4063, -4063, 0, 0,
       -7995, 90309, -7995, 0, 0,
       -1049, -1049, 97190, 0, 0,
       0, 0, 0, 65536, 0 },
    // lomo
    '{ 111411, 6554, 6554, 0, -4790682,
       0, 111411, 6554, 0, -4790682,
       0, 6554, 104858, 0, -4790682,
       0, 0, 0, 65536, 0 },
    // kodachrome
    '{ 73961, -26001, -2617, 0, 4176582,
       -10751, 71010, -3604, 0, 1620863,
       -11001, -36723, 104955, 0, 2335036,
       0, 0, 0, 65536, 0 },
    // technicolor
    '{ 125339, -56003, -6000, 0, 772906,
       -20236, 115729, -6948, 0, -4610592,
       -15146, -49164, 121084, 0, 2028401,
       0, 0, 0, 65536, 0 },
    // vintage
    '{ 41152, 20986, -2599, 0, 613753,
       1690, 42213, 2136, 0, 489084,
       3054, -5579, 34352, 0, 338113,
       0, 0, 0, 65536, 0 },
    // sepia
    '{ 25756, 50397, 12386, 0, 0,
       22872, 44958, 11010, 0, 0,
       17826, 34996, 8585, 0, 0,
       0, 0, 0, 65536, 0 }
  };

  // Working coefficient: master rescaled to COEF_FRAC_BITS, nearest, ties up.
  // Unused preset codes give an all-zero matrix, hence a zero result.
  function automatic coef_t coef_q(input preset_t preset, input cidx_t idx);
    int m;
    int r;
    m = 0;
    if ((preset < preset_t'(NUM_PRESETS)) && (idx < cidx_t'(NUM_COEF))) begin
      m = MASTER_TBL[preset][idx];
    end
    if (SHIFT > 0) begin
      r = (m + HALF_M) >>> SHIFT;
    end else begin
      r = m <<< (-SHIFT);
    end
    return coef_t'(r);
  endfunction

endpackage

// ===== src/cm45_row.sv =====
// One output channel of the color matrix: registered products, then sum,
// round and clamp into a registered channel value. Uses cm45_pkg.
`timescale 1ns / 1ps

module cm45_row (
  input  logic              clk,
  input  logic              en,
  input  cm45_pkg::preset_t preset,
  input  logic [1:0]        row,
  input  cm45_pkg::pix_t    pix,
  output cm45_pkg::chan_t   chan
);
  import cm45_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

  cidx_t                   base;
  logic signed [PROD_W-1:0] prod_nxt [NUM_CH];
  logic signed [PROD_W-1:0] prod_r   [NUM_CH];
  coef_t                   ofs_nxt;
  coef_t                   ofs_r;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] rnd;
  logic signed [SUM_W-1:0] q;
  chan_t                   chan_nxt;
  chan_t                   chan_r;

  assign base = cidx_t'(row) * cidx_t'(ROW_STRIDE);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod_nxt[c] = PROD_W'(coef_q(preset, base + cidx_t'(c)))
                    * PROD_W'($signed({1'b0, pix[c]}));
    end
    ofs_nxt = coef_q(preset, base + cidx_t'(OFS_COL));
  end

  always_comb begin
    sum = SUM_W'(ofs_r);
    for (int c = 0; c < NUM_CH; c++) begin
      sum = sum + SUM_W'(prod_r[c]);
    end
    rnd = sum + HALF_LSB;
    q   = rnd >>> COEF_FRAC_BITS;
    // clamp to the 8-bit range
    if (rnd < 0) begin
      chan_nxt = '0;
    end else if (q > SUM_W'(255)) begin
      chan_nxt = 8'hFF;
    end else begin
      chan_nxt = q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      ofs_r  <= ofs_nxt;
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

// ===== src/color_matrix_4x5_presets.sv =====
// Top level of the 4x5 color matrix with fixed look presets.
// Depends on cm45_pkg and cm45_row.
//
// Usage:
//   in_*  : stream of RGBA pixels, one item per handshake (tvalid & tready).
//   out_* : stream of transformed RGBA pixels, one item per input item,
//           in the same order.
//   cfg_* : cfg_wr_en writes cfg_wr_data into the preset register
//           (0 polaroid, 1 lomo, 2 kodachrome, 3 technicolor, 4 vintage,
//           5 sepia; 6 and 7 give all-zero pixels). Write only while idle.
// Pipeline: an accepted pixel is loaded into the input register, then moves
//   to the product register, then to the result register, which drives
//   out_tvalid; it is taken from there by the out_tready handshake.
// Throughput: one pixel per cycle when not stalled; the three registers
//   advance together. Stall: while out_tvalid is high and out_tready low
//   the whole pipe holds and in_tready drops; nothing is lost or repeated.
// Reset: synchronous on rst_n low; clears the valid bits and sets the
//   preset to polaroid. No clearing pass is needed.
`timescale 1ns / 1ps

module color_matrix_4x5_presets (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_red, in_green, in_blue, in_alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_red, out_green, out_blue, out_alpha
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data // look_preset
);
  import cm45_pkg::*;

  logic    pipe_en;
  logic    v1_r;
  logic    v2_r;
  logic    out_valid_r;
  pix_t    pix_r;
  preset_t preset_r;
  pix_t    res;

  // advance whenever the result register is empty or being taken
  assign pipe_en   = !out_valid_r || out_tready;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= '0;
    end else if (cfg_wr_en) begin
      preset_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pix_r <= in_tdata;
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_row
    cm45_row u_row (
      .clk    (clk),
      .en     (pipe_en),
      .preset (preset_r),
      .row    (2'(k)),
      .pix    (pix_r),
      .chan   (res[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res;

`ifndef SYNTH
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted item did not enter the input register");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && pipe_en) |=> out_tvalid)
    else $error("product stage item did not reach the result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !v1_r && !v2_r))
    else $error("valid bits not cleared by reset");
`endif

endmodule

// ===== bench/color_matrix_4x5_presets_tb.sv =====
// Self-checking bench for color_matrix_4x5_presets: streams RGBA pixels under
// every look preset, predicts each output pixel in fixed point and compares.
// Depends on cm45_pkg and the color_matrix_4x5_presets RTL.
`timescale 1ns / 1ps

module color_matrix_4x5_presets_tb;

  import cm45_pkg::*;

  typedef enum logic [2:0] {
    LOOK_POLAROID, LOOK_LOMO, LOOK_KODACHROME, LOOK_TECHNICOLOR,
    LOOK_VINTAGE, LOOK_SEPIA, LOOK_UNUSED6, LOOK_UNUSED7
  } look_e;

  localparam int TBL_FRAC     = 16;
  localparam int NUM_LOOKS    = 6;
  localparam int MAX_PAUSE    = 18;
  localparam int PIPE_DRAIN   = 6;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 400;
  localparam int MAX_PRINTS   = 40;

  // Q.16 coefficients per look: rows R, G, B, A; columns R, G, B, A, offset.
  localparam int LOOK_Q16 [NUM_LOOKS][20] = '{
    '{ 94241, -4063, -4063, 0, 0,
       -7995, 90309, -7995, 0, 0,
       -1049, -1049, 97190, 0, 0,
       0, 0, 0, 65536, 0 },
    '{ 111411, 6554, 6554, 0, -4790682,
       0, 111411, 6554, 0, -4790682,
       0, 6554, 104858, 0, -4790682,
       0, 0, 0, 65536, 0 },
    '{ 73961, -26001, -2617, 0, 4176582,
       -10751, 71010, -3604, 0, 1620863,
       -11001, -36723, 104955, 0, 2335036,
       0, 0, 0, 65536, 0 },
    '{ 125339, -56003, -6000, 0, 772906,
       -20236, 115729, -6948, 0, -4610592,
       -15146, -49164, 121084, 0, 2028401,
       0, 0, 0, 65536, 0 },
    '{ 41152, 20986, -2599, 0, 613753,
       1690, 42213, 2136, 0, 489084,
       3054, -5579, 34352, 0, 338113,
       0, 0, 0, 65536, 0 },
    '{ 25756, 50397, 12386, 0, 0,
       22872, 44958, 11010, 0, 0,
       17826, 34996, 8585, 0, 0,
       0, 0, 0, 65536, 0 }
  };

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // in_red, in_green, in_blue, in_alpha
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // out_red, out_green, out_blue, out_alpha
  logic        cfg_wr_en   = 1'b0;
  logic [2:0]  cfg_wr_data = '0;   // look_preset

  pix_t  pixel_q[$];
  pix_t  expect_q[$];
  look_e look_model;
  bit    in_taken, out_taken;
  bit    tx_pause_on, rx_pause_on;
  int    tx_gap, rx_gap;
  int    idle_cycles;
  int    n_pixels, n_checked, n_errors, n_phases;
  string chan_name [4] = '{"red", "green", "blue", "alpha"};

  color_matrix_4x5_presets dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Q.16 to working precision, nearest with ties toward +infinity.
  function automatic longint to_work_q(input int q16);
    int sh;
    sh = TBL_FRAC - COEF_FRAC_BITS;
    if (sh <= 0) return longint'(q16) <<< (-sh);
    return (longint'(q16) + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic pix_t matrix_pixel(input look_e look, input pix_t px);
    pix_t   res;
    longint acc;
    res = '0;
    if (look >= LOOK_UNUSED6) return res;
    for (int row = 0; row < 4; row++) begin
      acc = to_work_q(LOOK_Q16[look][row*5 + 4]);
      for (int col = 0; col < 4; col++) begin
        acc += to_work_q(LOOK_Q16[look][row*5 + col]) * longint'(px[col]);
      end
      acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
      if (acc < 0) begin
        res[row] = 8'd0;
      end else begin
        acc = acc >>> COEF_FRAC_BITS;
        res[row] = (acc > 255) ? 8'd255 : acc[7:0];
      end
    end
    return res;
  endfunction

  function automatic int pause_len(input bit on);
    return on ? int'($urandom_range(0, MAX_PAUSE)) : 0;
  endfunction

  // Lean toward the channel extremes so clamping gets exercised.
  function automatic pix_t rand_pixel();
    pix_t px;
    px = $urandom;
    if ($urandom_range(0, 9) < 6) begin
      for (int c = 0; c < 4; c++) begin
        case ($urandom_range(0, 3))
          0: px[c] = 8'd0;
          1: px[c] = 8'd255;
          default: px[c] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    return px;
  endfunction

  task automatic report(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sender: hold the item until taken, then pause before the next one.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_tdata  <= pixel_q.pop_front();
          in_tvalid <= 1'b1;
          tx_gap = pause_len(tx_pause_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each taken item stall for a drawn number of cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) rx_gap = pause_len(rx_pause_on);
      if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input handshakes, check on output handshakes.
  always @(posedge clk) begin
    pix_t got, want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst_n) begin
      look_model = LOOK_POLAROID;
    end else begin
      if (cfg_wr_en) look_model = look_e'(cfg_wr_data);
      in_taken  = in_tvalid && in_tready;
      out_taken = out_tvalid && out_tready;
      if (in_taken) begin
        expect_q.push_back(matrix_pixel(look_model, in_tdata));
        n_pixels++;
      end
      if (out_taken) begin
        got = out_tdata;
        if (expect_q.size() == 0) begin
          report("unexpected item", int'(got), 0);
        end else begin
          want = expect_q.pop_front();
          n_checked++;
          for (int c = 0; c < 4; c++) begin
            if (got[c] !== want[c]) report(chan_name[c], int'(got[c]), int'(want[c]));
          end
        end
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d pixels in flight", expect_q.size());
        $display("** color_matrix_4x5_presets: FAILED **");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_q.size() != 0 || expect_q.size() != 0 || in_tvalid);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_look(input look_e look);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= preset_t'(look);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    n_phases++;
  endtask

  initial begin
    look_e look;
    int    pick, sent, burst;
    tx_pause_on = 1'b1;
    rx_pause_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: black, white and a mixed pixel under every code, the reset
    // look first and the two unused codes last.
    for (int p = LOOK_POLAROID; p <= LOOK_UNUSED7; p++) begin
      if (p != LOOK_POLAROID) write_look(look_e'(p));
      pixel_q.push_back(32'h0000_0000);
      pixel_q.push_back(32'hFFFF_FFFF);
      pixel_q.push_back(32'h80FF_0080);
      wait_idle();
    end

    // Random phases; each writes a look and redraws the idling mix.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (sent == 0)    look = LOOK_POLAROID;
      else if (pick < 12) look = look_e'(pick % NUM_LOOKS);
      else if (pick < 14) look = LOOK_UNUSED6;
      else                look = LOOK_UNUSED7;
      write_look(look);
      tx_pause_on = ($urandom_range(0, 3) != 0);
      rx_pause_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(20, 60);
      repeat (burst) pixel_q.push_back(rand_pixel());
      sent += burst;
      wait_idle();
    end

    if (expect_q.size() != 0) report("pixels never returned", expect_q.size(), 0);
    $display("Covered %0d pixels over %0d look settings, %0d outputs compared,",
             n_pixels, n_phases + 1, n_checked);
    $display("with random sender gaps and receiver stalls; %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("** color_matrix_4x5_presets: PASSED **");
    end else begin
      $display("** color_matrix_4x5_presets: FAILED **");
    end
    $finish;
  end

endmodule
